// File: hdl/lfu_pkg.sv
// Shared constants and types for the LFU cache with LRU tiebreak.
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned HELD_W   = $clog2(CAPACITY + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } lfu_entry_t;

  localparam int unsigned ENTRY_W = $bits(lfu_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } lfu_state_e;

endpackage

// File: hdl/lfu_intf.sv
// Handshake interfaces: request, response and configuration channels.
`timescale 1ns / 1ps
interface lfu_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [lfu_pkg::KEY_W-1:0]        lookup_key;
  logic signed [lfu_pkg::DATA_W-1:0] write_value;

  modport source (output valid, req_type, lookup_key, write_value, input ready);
  modport sink   (input valid, req_type, lookup_key, write_value, output ready);
endinterface

interface lfu_resp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [lfu_pkg::DATA_W-1:0] read_value;
  logic                             evicted;
  logic [lfu_pkg::KEY_W-1:0]        evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lfu_pkg::CFG_W-1:0]   entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

// File: hdl/lfu_cache_with_lru_tiebreak.sv
// Top level: fully associative LFU cache with LRU tiebreak, scanned sequencer.
//
// Usage:
//   req_i  : one request per beat (get or put, key, write value).
//   resp_o : one response beat per request (hit, read value, eviction info).
//   cfg_i  : writes entries_in_use; always ready, write only while idle.
// Each request runs through a sequencer that scans the 16 entries of the
// entry RAM one per cycle. One compare/age unit checks each entry for a key
// match and keeps the running victim (lowest count, then oldest stamp).
// Steps: accept, scan of the entries, a drain step for the last RAM read,
// an update step (single RAM write), then a finish step that loads the
// response register. The next request is taken only once the sequencer is
// back in idle, so one request is handled at a time. With the cache
// disabled (entries_in_use 0) a request goes from accept straight to finish.
// The RAM read port sets the scan length: one entry per cycle.
// Reset: all entries invalid, use clock 0, entries_in_use 16; the entry RAM
// needs no clearing since valid bits gate every read.
// A stalled receiver holds the response register; the sequencer waits in
// its last step and takes no new request until the response can be loaded.
`timescale 1ns / 1ps
module lfu_cache_with_lru_tiebreak (
  input  logic           clk_i,
  input  logic           rst_ni,
  lfu_req_if.sink        req_i,
  lfu_resp_if.source     resp_o,
  lfu_cfg_if.sink        cfg_i
);

  lfu_pkg::lfu_state_e state_q, state_d;

  logic [lfu_pkg::CFG_W-1:0]    cfg_q;
  logic [lfu_pkg::CAPACITY-1:0] valid_q;
  logic [lfu_pkg::CAPACITY-1:0] valid_d;
  logic [lfu_pkg::HELD_W-1:0]   held_q;
  logic [lfu_pkg::STAMP_W-1:0]  clock_q;

  // latched request
  logic                         put_q;
  logic [lfu_pkg::KEY_W-1:0]    key_q;
  logic [lfu_pkg::DATA_W-1:0]   wval_q;

  // scan bookkeeping
  logic [lfu_pkg::IDX_W-1:0]    scan_q;
  logic                         rd_vld_q;
  logic [lfu_pkg::IDX_W-1:0]    rd_idx_q;

  logic                         match_q;
  logic [lfu_pkg::IDX_W-1:0]    match_slot_q;
  logic [lfu_pkg::DATA_W-1:0]   match_data_q;
  logic [lfu_pkg::COUNT_W-1:0]  match_cnt_q;

  logic                         best_found_q;
  logic [lfu_pkg::IDX_W-1:0]    best_slot_q;
  logic [lfu_pkg::COUNT_W-1:0]  best_cnt_q;
  logic [lfu_pkg::STAMP_W-1:0]  best_age_q;
  logic [lfu_pkg::KEY_W-1:0]    best_key_q;

  logic                         res_ev_q;

  // response register
  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [lfu_pkg::DATA_W-1:0]   out_rval_q;
  logic                         out_ev_q;
  logic [lfu_pkg::KEY_W-1:0]    out_evkey_q;

  // sequencer outputs
  logic                         req_ready;
  logic                         accept;
  logic                         scan_issue;
  logic                         do_update;
  logic                         load_out;

  logic [lfu_pkg::HELD_W-1:0]   cap;
  logic                         cap_zero;

  logic [lfu_pkg::ENTRY_W-1:0]  ram_rdata;
  lfu_pkg::lfu_entry_t          rd_entry;
  lfu_pkg::lfu_entry_t          wr_entry;
  logic                         ram_we;
  logic [lfu_pkg::IDX_W-1:0]    ram_waddr;

  logic [lfu_pkg::STAMP_W-1:0]  rd_age;
  logic                         rd_live;
  logic                         rd_match;
  logic                         rd_better;

  logic                         evicting;
  logic [lfu_pkg::CAPACITY-1:0] free_vec;
  logic                         free_any;
  logic [lfu_pkg::IDX_W-1:0]    free_slot;
  logic                         inserting;
  logic [lfu_pkg::COUNT_W-1:0]  bumped_cnt;

  assign cap = (32'(cfg_q) > 32'(lfu_pkg::CAPACITY)) ? lfu_pkg::HELD_W'(lfu_pkg::CAPACITY)
                                                      : lfu_pkg::HELD_W'(cfg_q);
  assign cap_zero = (cfg_q == '0);

  assign accept = req_i.valid && req_ready;

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cap_zero ? lfu_pkg::ST_FINISH : lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_q == lfu_pkg::IDX_W'(lfu_pkg::CAPACITY - 1)) begin
          state_d = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN:  state_d = lfu_pkg::ST_UPDATE;
      lfu_pkg::ST_UPDATE: state_d = lfu_pkg::ST_FINISH;
      lfu_pkg::ST_FINISH: begin
        if (!out_valid_q || resp_o.ready) begin
          state_d = lfu_pkg::ST_IDLE;
        end
      end
      default: state_d = lfu_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    req_ready  = 1'b0;
    scan_issue = 1'b0;
    do_update  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      lfu_pkg::ST_IDLE:   req_ready  = 1'b1;
      lfu_pkg::ST_SCAN:   scan_issue = 1'b1;
      lfu_pkg::ST_DRAIN:  ;
      lfu_pkg::ST_UPDATE: do_update  = 1'b1;
      lfu_pkg::ST_FINISH: load_out   = !out_valid_q || resp_o.ready;
      default: ;
    endcase
  end

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  // ---------------- entry RAM ----------------
  lfu_ram #(
    .WIDTH (lfu_pkg::ENTRY_W),
    .DEPTH (lfu_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = lfu_pkg::lfu_entry_t'(ram_rdata);

  // shared compare unit: one entry per cycle
  assign rd_age   = clock_q - rd_entry.stamp;
  assign rd_live  = rd_vld_q && valid_q[rd_idx_q];
  assign rd_match = rd_live && (rd_entry.key == key_q);
  assign rd_better = !best_found_q || (rd_entry.count < best_cnt_q) ||
                     ((rd_entry.count == best_cnt_q) && (rd_age > best_age_q));

  // ---------------- update step ----------------
  assign evicting = !match_q && (put_q == lfu_pkg::REQ_PUT) && (held_q >= cap) &&
                    best_found_q;

  always_comb begin
    free_vec = ~valid_q;
    if (evicting) begin
      free_vec[best_slot_q] = 1'b1;
    end
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = lfu_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_slot = lfu_pkg::IDX_W'(i);
      end
    end
  end

  assign free_any   = |free_vec;
  assign inserting  = !match_q && (put_q == lfu_pkg::REQ_PUT) && free_any;
  assign bumped_cnt = (match_cnt_q == '1) ? match_cnt_q : match_cnt_q + 1'b1;

  // victim slot cleared first, then the new entry claims its slot
  always_comb begin
    valid_d = valid_q;
    if (evicting) begin
      valid_d[best_slot_q] = 1'b0;
    end
    if (inserting) begin
      valid_d[free_slot] = 1'b1;
    end
  end

  always_comb begin
    wr_entry.key   = key_q;
    wr_entry.stamp = clock_q;
    if (match_q) begin
      wr_entry.data  = (put_q == lfu_pkg::REQ_PUT) ? wval_q : match_data_q;
      wr_entry.count = bumped_cnt;
    end else begin
      wr_entry.data  = wval_q;
      wr_entry.count = lfu_pkg::COUNT_W'(1);
    end
  end

  assign ram_we    = do_update && (match_q || inserting);
  assign ram_waddr = match_q ? match_slot_q : free_slot;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lfu_pkg::ST_IDLE;
      cfg_q        <= lfu_pkg::CFG_RESET;
      valid_q      <= '0;
      held_q       <= '0;
      clock_q      <= '0;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      match_q      <= 1'b0;
      best_found_q <= 1'b0;
      res_ev_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue;
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.entries_in_use;
      end
      if (accept) begin
        scan_q       <= '0;
        match_q      <= 1'b0;
        best_found_q <= 1'b0;
        res_ev_q     <= 1'b0;
      end else if (scan_issue) begin
        scan_q <= scan_q + 1'b1;
      end
      if (rd_match) begin
        match_q <= 1'b1;
      end
      if (rd_live && rd_better) begin
        best_found_q <= 1'b1;
      end
      if (do_update) begin
        res_ev_q <= evicting;
        valid_q  <= valid_d;
        if (match_q || inserting) begin
          clock_q <= clock_q + 1'b1;
        end
        if (inserting && !evicting) begin
          held_q <= held_q + 1'b1;
        end else if (evicting && !inserting) begin
          held_q <= held_q - 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (resp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      put_q  <= req_i.req_type;
      key_q  <= req_i.lookup_key;
      wval_q <= req_i.write_value;
    end
    rd_idx_q <= scan_q;
    if (rd_match && !match_q) begin
      match_slot_q <= rd_idx_q;
      match_data_q <= rd_entry.data;
      match_cnt_q  <= rd_entry.count;
    end
    if (rd_live && rd_better) begin
      best_slot_q <= rd_idx_q;
      best_cnt_q  <= rd_entry.count;
      best_age_q  <= rd_age;
      best_key_q  <= rd_entry.key;
    end
    if (load_out) begin
      out_hit_q   <= match_q;
      out_rval_q  <= (match_q && (put_q == lfu_pkg::REQ_GET)) ? match_data_q : '1;
      out_ev_q    <= res_ev_q;
      out_evkey_q <= res_ev_q ? best_key_q : '0;
    end
  end

  assign resp_o.valid       = out_valid_q;
  assign resp_o.hit         = out_hit_q;
  assign resp_o.read_value  = out_rval_q;
  assign resp_o.evicted     = out_ev_q;
  assign resp_o.evicted_key = out_evkey_q;

  // ---------------- assertions ----------------
  a_held_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(held_q))
    else $error("entry count out of step with valid bits");

  a_resp_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lfu_pkg::ST_FINISH))
    else $error("response raised outside the finish step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == lfu_pkg::ST_SCAN || state_q == lfu_pkg::ST_FINISH))
    else $error("sequencer did not start after request beat");

  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp_o.valid && resp_o.evicted) |-> !resp_o.hit)
    else $error("eviction reported on a hit");

  a_one_write_per_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == lfu_pkg::ST_UPDATE)
    else $error("entry RAM written outside the update step");

endmodule

// File: hdl/lfu_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/lfu_cache_with_lru_tiebreak_tb.sv
// Self-checking testbench for the LFU cache with LRU tiebreak: directed and random traffic.
`timescale 1ns / 1ps

typedef struct packed {
  logic                       hit;
  logic [lfu_pkg::DATA_W-1:0] read_value;
  logic                       evicted;
  logic [lfu_pkg::KEY_W-1:0]  evicted_key;
} cache_resp_t;

// Mirror of the cache contents; predicts each response as requests are accepted.
class lfu_shadow_cache;
  bit                          slot_valid [lfu_pkg::CAPACITY];
  bit [lfu_pkg::KEY_W-1:0]     slot_key   [lfu_pkg::CAPACITY];
  bit [lfu_pkg::DATA_W-1:0]    slot_data  [lfu_pkg::CAPACITY];
  bit [lfu_pkg::COUNT_W-1:0]   slot_count [lfu_pkg::CAPACITY];
  bit [lfu_pkg::STAMP_W-1:0]   slot_stamp [lfu_pkg::CAPACITY];
  bit [lfu_pkg::STAMP_W-1:0]   use_clock;
  int unsigned                 held;
  bit [lfu_pkg::CFG_W-1:0]     allowed;
  cache_resp_t                 owed_resp [$];
  int unsigned                 requests, checked, mismatches, hits, evictions;

  function new();
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    use_clock  = '0;
    held       = 0;
    allowed    = lfu_pkg::CFG_RESET;
    requests   = 0;
    checked    = 0;
    mismatches = 0;
    hits       = 0;
    evictions  = 0;
  endfunction

  function void note_request(logic op, logic [lfu_pkg::KEY_W-1:0] key,
                             logic [lfu_pkg::DATA_W-1:0] wval);
    cache_resp_t                 want;
    int unsigned                 limit;
    int                          found, victim, free_slot;
    bit [lfu_pkg::STAMP_W-1:0]   age, best_age;
    want.hit         = 1'b0;
    want.read_value  = '1;
    want.evicted     = 1'b0;
    want.evicted_key = '0;
    limit     = (allowed > lfu_pkg::CAPACITY) ? lfu_pkg::CAPACITY : allowed;
    found     = -1;
    victim    = -1;
    free_slot = -1;
    best_age  = '0;
    requests++;
    if (limit != 0) begin
      for (int i = 0; i < lfu_pkg::CAPACITY; i++)
        if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      if (found >= 0) begin
        want.hit = 1'b1;
        if (slot_count[found] != '1) slot_count[found]++;
        slot_stamp[found] = use_clock;
        use_clock++;
        if (op == lfu_pkg::REQ_PUT) slot_data[found] = wval;
        else want.read_value = slot_data[found];
        hits++;
      end else if (op == lfu_pkg::REQ_PUT) begin
        // full (or over a shrunk limit): drop exactly one, lowest count then oldest
        if (held >= limit) begin
          for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
            if (slot_valid[i]) begin
              age = use_clock - slot_stamp[i];
              if (victim < 0 || slot_count[i] < slot_count[victim] ||
                  (slot_count[i] == slot_count[victim] && age > best_age)) begin
                victim   = i;
                best_age = age;
              end
            end
          end
          if (victim >= 0) begin
            want.evicted       = 1'b1;
            want.evicted_key   = slot_key[victim];
            slot_valid[victim] = 1'b0;
            held--;
            evictions++;
          end
        end
        for (int i = 0; i < lfu_pkg::CAPACITY; i++)
          if (free_slot < 0 && !slot_valid[i]) free_slot = i;
        if (free_slot >= 0) begin
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = key;
          slot_data[free_slot]  = wval;
          slot_count[free_slot] = lfu_pkg::COUNT_W'(1);
          slot_stamp[free_slot] = use_clock;
          use_clock++;
          held++;
        end
      end
    end
    owed_resp.push_back(want);
  endfunction

  function void check_response(cache_resp_t got);
    cache_resp_t want;
    if (owed_resp.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: response beat with none outstanding: hit=%b value=%h evicted=%b key=%h",
                 $time, got.hit, got.read_value, got.evicted, got.evicted_key);
      mismatches++;
      return;
    end
    want = owed_resp.pop_front();
    checked++;
    if (got.hit !== want.hit || got.read_value !== want.read_value ||
        got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
      if (mismatches < 10) begin
        $display("%0t: response %0d mismatch", $time, checked);
        $display("  expected hit=%b value=%h evicted=%b key=%h",
                 want.hit, want.read_value, want.evicted, want.evicted_key);
        $display("  actual   hit=%b value=%h evicted=%b key=%h",
                 got.hit, got.read_value, got.evicted, got.evicted_key);
      end
      mismatches++;
    end
  endfunction
endclass

module lfu_cache_with_lru_tiebreak_tb;

  localparam logic [lfu_pkg::CFG_W-1:0] SEG_LIMITS [6] =
    '{5'd16, 5'd3, 5'd1, 5'd31, 5'd6, 5'd17};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 48;

  lfu_shadow_cache shadow = new();

  lfu_req_if  req_if ();
  lfu_resp_if resp_if ();
  lfu_cfg_if  cfg_if ();

  lfu_cache_with_lru_tiebreak u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .resp_o (resp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    resp_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && resp_if.valid && resp_if.ready)
      shadow.check_response(cache_resp_t'{resp_if.hit, resp_if.read_value,
                                          resp_if.evicted, resp_if.evicted_key});
  end

  task automatic send_request(logic op, logic [lfu_pkg::KEY_W-1:0] key,
                              logic [lfu_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= op;
    req_if.lookup_key  <= key;
    req_if.write_value <= value;
    do @(posedge clk); while (!req_if.ready);
    shadow.note_request(op, key, value);
  endtask

  // settle the block before touching the limit register
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (shadow.owed_resp.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_limit(logic [lfu_pkg::CFG_W-1:0] limit);
    cfg_if.valid          <= 1'b1;
    cfg_if.entries_in_use <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow.allowed = limit;
  endtask

  initial begin
    logic [lfu_pkg::KEY_W-1:0]  key;
    logic [lfu_pkg::KEY_W-1:0]  key_pool [$];
    logic                       op;
    int unsigned                pool_n;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= lfu_pkg::REQ_GET;
    req_if.lookup_key     <= '0;
    req_if.write_value    <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.entries_in_use <= lfu_pkg::CFG_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty cache, key extremes, a stored -1, update of a present key
    send_request(lfu_pkg::REQ_GET, 16'h0000, 32'h0000_0000);
    send_request(lfu_pkg::REQ_PUT, 16'h0000, 32'hFFFF_FFFF);
    send_request(lfu_pkg::REQ_GET, 16'h0000, 32'h1234_5678);
    send_request(lfu_pkg::REQ_PUT, 16'hFFFF, 32'h7FFF_FFFF);
    send_request(lfu_pkg::REQ_PUT, 16'hFFFF, 32'h8000_0000);
    send_request(lfu_pkg::REQ_GET, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(lfu_pkg::REQ_PUT, 16'h00AA, 32'h0000_0000);
    send_request(lfu_pkg::REQ_PUT, 16'h5500, 32'h1234_5678);

    // disabled: entries kept but unreachable, puts dropped
    drain();
    write_limit(5'd0);
    send_request(lfu_pkg::REQ_GET, 16'hFFFF, 32'h0);
    send_request(lfu_pkg::REQ_PUT, 16'h1111, 32'hA5A5_A5A5);

    // limit below what is held: each new key evicts exactly one
    drain();
    write_limit(5'd2);
    send_request(lfu_pkg::REQ_GET, 16'h1111, 32'h0);
    send_request(lfu_pkg::REQ_PUT, 16'h2222, 32'h0000_2222);
    send_request(lfu_pkg::REQ_PUT, 16'h3333, 32'h0000_3333);
    send_request(lfu_pkg::REQ_GET, 16'h2222, 32'h0);
    send_request(lfu_pkg::REQ_PUT, 16'h4444, 32'h0000_4444);
    send_request(lfu_pkg::REQ_GET, 16'h4444, 32'h0);
    send_request(lfu_pkg::REQ_PUT, 16'h0000, 32'h0000_0005);

    // oversized register acts as full capacity
    drain();
    write_limit(5'd31);
    send_request(lfu_pkg::REQ_PUT, 16'h6666, 32'h0000_6666);
    send_request(lfu_pkg::REQ_GET, 16'h6666, 32'h0);
    send_request(lfu_pkg::REQ_GET, 16'h0000, 32'h0);

    drain();
    write_limit(5'd1);
    send_request(lfu_pkg::REQ_PUT, 16'h7777, 32'h0000_7777);
    send_request(lfu_pkg::REQ_PUT, 16'h8888, 32'h0000_8888);

    // random traffic over a small hot key set per limit setting
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      write_limit(SEG_LIMITS[seg]);
      if (seg < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 48;
      end else if (seg < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pool_n = ((SEG_LIMITS[seg] > lfu_pkg::CAPACITY) ? lfu_pkg::CAPACITY
                                                      : SEG_LIMITS[seg]) + 3;
      key_pool.delete();
      repeat (pool_n) key_pool.push_back(lfu_pkg::KEY_W'($urandom_range(16'hFFFF)));
      repeat (63) begin
        if ($urandom_range(9) == 0) key = lfu_pkg::KEY_W'($urandom());
        else key = key_pool[$urandom_range(key_pool.size() - 1)];
        op = ($urandom_range(1) == 1) ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET;
        send_request(op, key, $urandom());
      end
    end

    req_if.valid <= 1'b0;
    while (shadow.owed_resp.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);

    $display("Ran %0d requests (%0d responses checked) across limits 0, 1, 2, 3, 6, 16, 17, 31",
             shadow.requests, shadow.checked);
    $display("Saw %0d hits and %0d evictions under three pacing modes; %0d mismatches",
             shadow.hits, shadow.evictions, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.owed_resp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d responses outstanding", shadow.owed_resp.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
